// ===== hdl/session_lease_watchdog_macros.svh =====
// Assertion macros for the session lease watchdog.
// Used by the RTL modules that carry concurrent checks; no other dependencies.
`ifndef SESSION_LEASE_WATCHDOG_MACROS_SVH
`define SESSION_LEASE_WATCHDOG_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted
`define SLW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("session lease watchdog check failed");
// Next-cycle implication, disabled while reset is asserted
`define SLW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("session lease watchdog check failed");
`else
`define SLW_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SLW_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/slw_pkg.sv =====
// Shared types and constants for the session lease watchdog.
// No dependencies; imported by slw_eval and session_lease_watchdog.
`default_nettype none

package slw_pkg;

    // Field and register widths
    localparam int TIME_W = 64;
    localparam int TAG_W  = 32;
    localparam int CODE_W = 3;
    localparam int CFG_W  = 40;
    localparam int DATA_W = 64;
    localparam int ADDR_W = 4;

    // Request kinds
    typedef enum logic [1:0] {
        REQ_AUTH   = 2'd0,
        REQ_ACT    = 2'd1,
        REQ_TICK   = 2'd2,
        REQ_REVOKE = 2'd3
    } req_kind_t;

    // Stop codes
    localparam logic [CODE_W-1:0] STOP_NONE         = 3'd0;
    localparam logic [CODE_W-1:0] STOP_USER         = 3'd1;
    localparam logic [CODE_W-1:0] STOP_IDLE         = 3'd3;
    localparam logic [CODE_W-1:0] STOP_LIFETIME     = 3'd4;
    localparam logic [CODE_W-1:0] STOP_SAFETY       = 3'd5;
    localparam logic [CODE_W-1:0] STOP_START_FAILED = 3'd6;

    // Register index, taken from paddr[3]
    localparam logic REG_IDLE_TIMEOUT = 1'b0;
    localparam logic REG_MAX_LIFETIME = 1'b1;

    // Register reset values
    localparam logic [CFG_W-1:0] IDLE_TIMEOUT_RST = 40'd300000000;
    localparam logic [CFG_W-1:0] MAX_LIFETIME_RST = 40'd1800000000;

    // Incoming item
    typedef struct packed {
        req_kind_t          req_type;
        logic [TIME_W-1:0]  now_us;
        logic [TAG_W-1:0]   session_tag;
        logic [CODE_W-1:0]  revoke_reason;
    } req_t;

    // Outgoing item
    typedef struct packed {
        logic               ok;
        logic               is_authorized;
        logic [CODE_W-1:0]  stop_code;
        logic [TAG_W-1:0]   current_tag;
    } rsp_t;

    // Session state held between items
    typedef struct packed {
        logic               is_open;
        logic [TAG_W-1:0]   tag;
        logic [TIME_W-1:0]  start_us;
        logic [TIME_W-1:0]  last_us;
        logic [CODE_W-1:0]  stop;
    } sess_t;

endpackage

`default_nettype wire

// ===== hdl/slw_eval.sv =====
// Combinational evaluation of one request against the session state.
// Depends on slw_pkg; instantiated by session_lease_watchdog.
`default_nettype none

module slw_eval
    import slw_pkg::*;
(
    input  wire sess_t             cur,
    input  wire req_t              item,
    input  wire logic [CFG_W-1:0]  idle_limit,
    input  wire logic [CFG_W-1:0]  life_limit,
    output sess_t                  nxt,
    output rsp_t                   res
);

    logic [TIME_W-1:0] since_start;
    logic [TIME_W-1:0] since_active;
    logic              no_rewind;
    logic              life_hit;
    logic              idle_hit;
    logic              tag_match;
    logic [CODE_W-1:0] revoke_code;
    logic              ok;
    sess_t             closed;

    // Elapsed times and limit checks
    assign since_start  = item.now_us - cur.start_us;
    assign since_active = item.now_us - cur.last_us;
    assign no_rewind    = (item.now_us >= cur.start_us) && (item.now_us >= cur.last_us);
    assign life_hit     = since_start >= {{(TIME_W-CFG_W){1'b0}}, life_limit};
    assign idle_hit     = since_active >= {{(TIME_W-CFG_W){1'b0}}, idle_limit};
    assign tag_match    = (item.session_tag != '0) && (item.session_tag == cur.tag);

    // Revoke reason: none becomes user, out-of-range saturates
    always_comb
    begin
        if (item.revoke_reason == STOP_NONE)
            revoke_code = STOP_USER;
        else if (item.revoke_reason > STOP_START_FAILED)
            revoke_code = STOP_START_FAILED;
        else
            revoke_code = item.revoke_reason;
    end

    // Closed-session template; stop code filled in per case
    always_comb
    begin
        closed          = '0;
        closed.stop     = cur.stop;
    end

    // Request decode and state update
    always_comb
    begin
        nxt = cur;
        ok  = 1'b0;
        unique case (item.req_type)
            REQ_AUTH:
            begin
                if (!cur.is_open && (item.now_us != '0) && (item.session_tag != '0))
                begin
                    nxt.is_open  = 1'b1;
                    nxt.tag      = item.session_tag;
                    nxt.start_us = item.now_us;
                    nxt.last_us  = item.now_us;
                    nxt.stop     = STOP_NONE;
                    ok           = 1'b1;
                end
            end
            REQ_ACT:
            begin
                if (cur.is_open && tag_match && no_rewind)
                begin
                    if (life_hit)
                    begin
                        nxt      = closed;
                        nxt.stop = STOP_LIFETIME;
                    end
                    else if (idle_hit)
                    begin
                        nxt      = closed;
                        nxt.stop = STOP_IDLE;
                    end
                    else
                    begin
                        nxt.last_us = item.now_us;
                        ok          = 1'b1;
                    end
                end
            end
            REQ_TICK:
            begin
                if (cur.is_open)
                begin
                    if (!no_rewind)
                    begin
                        nxt      = closed;
                        nxt.stop = STOP_SAFETY;
                        ok       = 1'b1;
                    end
                    else if (life_hit)
                    begin
                        nxt      = closed;
                        nxt.stop = STOP_LIFETIME;
                        ok       = 1'b1;
                    end
                    else if (idle_hit)
                    begin
                        nxt      = closed;
                        nxt.stop = STOP_IDLE;
                        ok       = 1'b1;
                    end
                end
            end
            REQ_REVOKE:
            begin
                nxt      = closed;
                nxt.stop = revoke_code;
                ok       = 1'b1;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

    // Result item reflects the state after this request
    always_comb
    begin
        res.ok            = ok;
        res.is_authorized = nxt.is_open;
        res.stop_code     = nxt.stop;
        res.current_tag   = nxt.is_open ? nxt.tag : '0;
    end

endmodule

`default_nettype wire

// ===== hdl/session_lease_watchdog.sv =====
// Session lease watchdog: an accepted item sits in the input register and is evaluated into
// the result register once that register is free or being drained by rsp_ready.
// Throughput is one item per cycle while rsp_ready holds; the 64-bit elapsed-time subtract
// and compare pair in slw_eval sets the cycle time.
// rst_n (async, active low) closes the session, clears the stop code to none
// and restores the idle and lifetime limits to their defaults.
`default_nettype none
`include "session_lease_watchdog_macros.svh"

module session_lease_watchdog
    import slw_pkg::*;
(
    input  wire                     clk,
    input  wire                     rst_n,
    // request channel
    input  wire                     req_valid,
    output logic                    req_ready,
    input  wire req_t               req,
    // result channel
    output logic                    rsp_valid,
    input  wire                     rsp_ready,
    output rsp_t                    rsp,
    // configuration port
    input  wire                     psel,
    input  wire                     penable,
    input  wire                     pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready
);

    logic              hold_valid_reg;
    req_t              hold_reg;
    logic              rsp_valid_reg;
    rsp_t              rsp_reg;
    sess_t             sess_reg;
    sess_t             sess_next;
    rsp_t              rsp_next;
    logic [CFG_W-1:0]  idle_limit_reg;
    logic [CFG_W-1:0]  life_limit_reg;
    logic              advance;
    logic              cfg_write;

    // Handshake: evaluate when the result register is free or being drained
    assign advance   = hold_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !hold_valid_reg || advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Control and session state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            sess_reg       <= '0;
        end
        else
        begin
            if (req_valid && req_ready)
                hold_valid_reg <= 1'b1;
            else if (advance)
                hold_valid_reg <= 1'b0;

            if (advance)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;

            if (advance)
                sess_reg <= sess_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
            hold_reg <= req;
        if (advance)
            rsp_reg <= rsp_next;
    end

    // Request evaluation
    slw_eval u_eval (
        .cur        (sess_reg),
        .item       (hold_reg),
        .idle_limit (idle_limit_reg),
        .life_limit (life_limit_reg),
        .nxt        (sess_next),
        .res        (rsp_next)
    );

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_limit_reg <= IDLE_TIMEOUT_RST;
            life_limit_reg <= MAX_LIFETIME_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3])
                REG_IDLE_TIMEOUT: idle_limit_reg <= pwdata[CFG_W-1:0];
                REG_MAX_LIFETIME: life_limit_reg <= pwdata[CFG_W-1:0];
                default:          idle_limit_reg <= idle_limit_reg;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        unique case (paddr[3])
            REG_IDLE_TIMEOUT: prdata = {{(DATA_W-CFG_W){1'b0}}, idle_limit_reg};
            REG_MAX_LIFETIME: prdata = {{(DATA_W-CFG_W){1'b0}}, life_limit_reg};
            default:          prdata = '0;
        endcase
    end

    // Checks
    `SLW_ASSERT_NOW(a_closed_no_tag, clk, rst_n, !sess_reg.is_open, sess_reg.tag == '0)
    `SLW_ASSERT_NOW(a_open_no_stop, clk, rst_n, sess_reg.is_open, sess_reg.stop == STOP_NONE)
    `SLW_ASSERT_NOW(a_rsp_tag, clk, rst_n, rsp_valid, rsp.is_authorized == (rsp.current_tag != '0))
    `SLW_ASSERT_NEXT(a_revoke_closes, clk, rst_n, advance && (hold_reg.req_type == REQ_REVOKE), !sess_reg.is_open && rsp_reg.ok)

endmodule

`default_nettype wire
